// ===== src/pqm_pkg.sv =====
// ============================================================================
// pqm_pkg
// Shared types and constants for the max-priority queue: field widths,
// command and status codes, controller states and the control/status bundles.
// ============================================================================
`default_nettype none

package pqm_pkg;

    localparam int VALUE_W      = 32;
    localparam int PRIO_FIELD_W = 16;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;

    // Request command codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    issue;       // read the store at the pointer and advance it
        logic    scan_start;  // clear the pointer and the running best
        logic    scan_cmp;    // compare the read-back entry with the best
        logic    shift_load;  // point just past the selected entry
        logic    shift_wr;    // write read-back entries one slot lower
        logic    enq_write;   // store the request at the tail
        logic    reply;       // load the response register
        logic    reply_deq;   // the response carries the removed entry
        status_t reply_code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_last;
        logic shift_more;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/pqm_ifs.sv =====
// ============================================================================
// pqm_ifs
// Valid/ready channels of the queue: the request channel and the response
// channel, each with a source and a sink modport.
// ============================================================================
`default_nettype none

interface pqm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic signed [pqm_pkg::VALUE_W-1:0]   item_value;
    logic [pqm_pkg::PRIO_FIELD_W-1:0]     item_priority;

    modport source (output valid, output cmd, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_priority,
                    output ready);
endinterface

interface pqm_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [pqm_pkg::STATUS_W-1:0]         status;
    logic signed [pqm_pkg::VALUE_W-1:0]   out_value;
    logic [pqm_pkg::PRIO_FIELD_W-1:0]     out_priority;
    logic [pqm_pkg::FILL_W-1:0]           fill_level;

    modport source (output valid, output status, output out_value, output out_priority,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                     input fill_level, output ready);
endinterface

`default_nettype wire

// ===== src/priority_queue_max_unit.sv =====
// Response: an enqueue, or any request answered with overflow or underflow, has its
// response in the cycle after acceptance. A dequeue scans the held entries, moves
// the entries newer than the removed one down a slot, and then answers.
// Throughput: one request at a time; the next is taken once the response leaves.
// The scan and compaction through the one read and one write port set the dequeue time.
// Reset clears the fill count, pointer, valid flags and control state; no clearing pass.
// ============================================================================
// priority_queue_max_unit
// Bounded priority queue that hands back its highest-priority entry, the
// newest one winning among equal priorities.
// ============================================================================
`default_nettype none

module priority_queue_max_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pqm_req_if.sink    req,
    pqm_rsp_if.source  rsp
);

    // The entries sit in a memory in arrival order, so recency is the slot
    // number and needs no stored age. A dequeue reads the store from the
    // oldest slot up, keeping the best entry so far; a later slot of equal
    // priority replaces it, which gives the newest entry the win on a tie.
    // The entries above the selected one are then moved down a slot, one
    // request per cycle through the read and write ports, keeping the order.

    pqm_pkg::ctrl_cmd_t  ctrl;
    pqm_pkg::dp_status_t stat;
    logic                in_ready;

    pqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .in_ready  (in_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    pqm_dpath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .status        (rsp.status),
        .out_value     (rsp.out_value),
        .out_priority  (rsp.out_priority),
        .fill_level    (rsp.fill_level)
    );

    // A request is taken only while the controller is idle and the response
    // register is empty or being emptied in the same cycle.
    assign req.ready = in_ready;

endmodule

`default_nettype wire

// ===== src/pqm_ctrl.sv =====
// ============================================================================
// pqm_ctrl
// Controller of the queue: accepts requests, sequences the scan for the
// highest priority, the compaction of the store and the response.
// ============================================================================
`default_nettype none

module pqm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_cmd,
    output logic                     in_ready,
    input  wire pqm_pkg::dp_status_t stat,
    output pqm_pkg::ctrl_cmd_t       ctrl
);

    pqm_pkg::state_t state_reg;
    pqm_pkg::state_t state_next;
    logic            accept;

    assign in_ready = (state_reg == pqm_pkg::ST_IDLE) && stat.out_free;
    assign accept   = req_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pqm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pqm_pkg::ST_IDLE:
            begin
                if (accept && req_cmd == pqm_pkg::CMD_DEQUEUE && !stat.empty)
                begin
                    state_next = pqm_pkg::ST_SCAN;
                end
            end
            pqm_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = pqm_pkg::ST_DRAIN;
                end
            end
            pqm_pkg::ST_DRAIN:
            begin
                state_next = pqm_pkg::ST_SHIFT;
            end
            pqm_pkg::ST_SHIFT:
            begin
                if (!stat.shift_more)
                begin
                    state_next = pqm_pkg::ST_FLUSH;
                end
            end
            pqm_pkg::ST_FLUSH:
            begin
                state_next = pqm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pqm_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        ctrl            = '0;
        ctrl.reply_code = pqm_pkg::STATUS_OK;
        case (state_reg)
            pqm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_cmd == pqm_pkg::CMD_ENQUEUE)
                    begin
                        ctrl.reply = 1'b1;
                        if (stat.full)
                        begin
                            ctrl.reply_code = pqm_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            ctrl.enq_write = 1'b1;
                        end
                    end
                    else if (stat.empty)
                    begin
                        ctrl.reply      = 1'b1;
                        ctrl.reply_code = pqm_pkg::STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.scan_start = 1'b1;
                    end
                end
            end
            pqm_pkg::ST_SCAN:
            begin
                ctrl.issue    = 1'b1;
                ctrl.scan_cmp = 1'b1;
            end
            pqm_pkg::ST_DRAIN:
            begin
                ctrl.scan_cmp   = 1'b1;
                ctrl.shift_load = 1'b1;
            end
            pqm_pkg::ST_SHIFT:
            begin
                ctrl.issue    = stat.shift_more;
                ctrl.shift_wr = 1'b1;
            end
            pqm_pkg::ST_FLUSH:
            begin
                ctrl.shift_wr  = 1'b1;
                ctrl.reply     = 1'b1;
                ctrl.reply_deq = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pqm_dpath.sv =====
// ============================================================================
// pqm_dpath
// Datapath of the queue: the entry store kept in arrival order, the scan
// comparator with its running best, the compaction path and the response
// register.
// ============================================================================
`default_nettype none

module pqm_dpath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire pqm_pkg::ctrl_cmd_t                    ctrl,
    output pqm_pkg::dp_status_t                        stat,
    input  wire logic signed [pqm_pkg::VALUE_W-1:0]    item_value,
    input  wire logic [pqm_pkg::PRIO_FIELD_W-1:0]      item_priority,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [pqm_pkg::STATUS_W-1:0]               status,
    output logic signed [pqm_pkg::VALUE_W-1:0]         out_value,
    output logic [pqm_pkg::PRIO_FIELD_W-1:0]           out_priority,
    output logic [pqm_pkg::FILL_W-1:0]                 fill_level
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Entry store: slot 0 holds the oldest entry, slot count-1 the newest.
    logic signed [pqm_pkg::VALUE_W-1:0] mem_val [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0]           mem_pri [QUEUE_DEPTH];

    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [CNT_W-1:0]                   ptr_reg, ptr_next;
    logic                               pipe_vld_reg;
    logic [IDX_W-1:0]                   pipe_idx_reg;
    logic signed [pqm_pkg::VALUE_W-1:0] rd_val_reg;
    logic [PRIORITY_BITS-1:0]           rd_pri_reg;

    logic                               best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]                   best_idx_reg, best_idx_next;
    logic signed [pqm_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic [PRIORITY_BITS-1:0]           best_pri_reg, best_pri_next;

    logic                               res_vld_reg;
    pqm_pkg::status_t                   res_status_reg;
    logic signed [pqm_pkg::VALUE_W-1:0] res_val_reg;
    logic [pqm_pkg::PRIO_FIELD_W-1:0]   res_pri_reg;
    logic [pqm_pkg::FILL_W-1:0]         res_fill_reg;

    logic                               take_new;
    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    logic [IDX_W-1:0]                   rd_addr;
    logic signed [pqm_pkg::VALUE_W-1:0] wr_val;
    logic [PRIORITY_BITS-1:0]           wr_pri;

    assign rd_addr = ptr_reg[IDX_W-1:0];

    // Later slots are newer, so an equal priority replaces the running best.
    assign take_new = ctrl.scan_cmp && pipe_vld_reg
                      && (!best_vld_reg || rd_pri_reg >= best_pri_reg);

    always_comb
    begin
        best_vld_next = best_vld_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        if (ctrl.scan_start)
        begin
            best_vld_next = 1'b0;
        end
        else if (take_new)
        begin
            best_vld_next = 1'b1;
            best_idx_next = pipe_idx_reg;
            best_val_next = rd_val_reg;
            best_pri_next = rd_pri_reg;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.scan_start)
        begin
            ptr_next = '0;
        end
        else if (ctrl.shift_load)
        begin
            ptr_next = CNT_W'(best_idx_next) + CNT_W'(1);
        end
        else if (ctrl.issue)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.enq_write)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctrl.reply_deq)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // One write port: the tail on an enqueue, or one slot down while compacting.
    assign wr_en   = ctrl.enq_write || (ctrl.shift_wr && pipe_vld_reg);
    assign wr_addr = ctrl.enq_write ? cnt_reg[IDX_W-1:0] : pipe_idx_reg - IDX_W'(1);
    assign wr_val  = ctrl.enq_write ? item_value : rd_val_reg;
    assign wr_pri  = ctrl.enq_write ? PRIORITY_BITS'(item_priority) : rd_pri_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_val[wr_addr] <= wr_val;
            mem_pri[wr_addr] <= wr_pri;
        end
        if (ctrl.issue)
        begin
            rd_val_reg <= mem_val[rd_addr];
            rd_pri_reg <= mem_pri[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ptr_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            ptr_reg      <= ptr_next;
            pipe_vld_reg <= ctrl.issue;
            best_vld_reg <= best_vld_next;
            if (ctrl.reply)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            pipe_idx_reg <= rd_addr;
        end
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        if (ctrl.reply)
        begin
            res_status_reg <= ctrl.reply_code;
            res_val_reg    <= ctrl.reply_deq ? best_val_reg : '0;
            res_pri_reg    <= ctrl.reply_deq ? pqm_pkg::PRIO_FIELD_W'(best_pri_reg) : '0;
            res_fill_reg   <= pqm_pkg::FILL_W'(cnt_next);
        end
    end

    assign stat.full       = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty      = (cnt_reg == '0);
    assign stat.scan_last  = ((ptr_reg + CNT_W'(1)) == cnt_reg);
    assign stat.shift_more = (ptr_reg < cnt_reg);
    assign stat.out_free   = !res_vld_reg || out_ready;

    assign out_valid    = res_vld_reg;
    assign status       = res_status_reg;
    assign out_value    = res_val_reg;
    assign out_priority = res_pri_reg;
    assign fill_level   = res_fill_reg;

endmodule

`default_nettype wire

// ===== src/pqm_checker.sv =====
// ============================================================================
// pqm_checker
// Port-level checks of the queue's request and response behaviour, bound to
// the top level.
// ============================================================================
`default_nettype none

module pqm_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 req_valid,
    input wire logic                                 req_ready,
    input wire logic                                 req_cmd,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [pqm_pkg::STATUS_W-1:0]         rsp_status,
    input wire logic signed [pqm_pkg::VALUE_W-1:0]   rsp_out_value,
    input wire logic [pqm_pkg::PRIO_FIELD_W-1:0]     rsp_out_priority,
    input wire logic [pqm_pkg::FILL_W-1:0]           rsp_fill_level
);

    // A stalled response keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_out_value) && $stable(rsp_out_priority)
            && $stable(rsp_fill_level))
        else $error("stalled response changed");

    // No request is taken while a response waits to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !(rsp_valid && !rsp_ready))
        else $error("request taken while response stalled");

    // An enqueue is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_cmd == pqm_pkg::CMD_ENQUEUE |=> rsp_valid)
        else $error("enqueue not answered in the next cycle");

    // Underflow leaves an empty queue and returns no entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == pqm_pkg::STATUS_UNDERFLOW |->
            rsp_out_value == '0 && rsp_out_priority == '0 && rsp_fill_level == '0)
        else $error("underflow response malformed");

    // Overflow only happens on a full queue and returns no entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == pqm_pkg::STATUS_OVERFLOW |->
            rsp_fill_level == pqm_pkg::FILL_W'(QUEUE_DEPTH)
            && rsp_out_value == '0 && rsp_out_priority == '0)
        else $error("overflow response malformed");

endmodule

bind priority_queue_max_unit pqm_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pqm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_cmd          (req.cmd),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_out_value    (rsp.out_value),
    .rsp_out_priority (rsp.out_priority),
    .rsp_fill_level   (rsp.fill_level)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the max-priority queue. It sends a directed run of
// requests and then about 950 random ones, and checks every response
// field by field against its own model of the entry store. Both channels
// idle at random. One long receiver hold-off makes the queue stall its input.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 16;
    localparam int RANDOM_REQS = 950;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 500;
    localparam int CALM_TO     = 650;
    localparam int IDLE_PCT    = 26;

    // One request as the sender offers it.
    typedef struct {
        logic                                cmd;
        logic signed [pqm_pkg::VALUE_W-1:0]  value;
        logic [pqm_pkg::PRIO_FIELD_W-1:0]    prio;
    } queue_req_t;

    // One response as the queue should return it.
    typedef struct {
        pqm_pkg::status_t                    status;
        logic signed [pqm_pkg::VALUE_W-1:0]  value;
        logic [pqm_pkg::PRIO_FIELD_W-1:0]    prio;
        logic [pqm_pkg::FILL_W-1:0]          fill;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    pqm_req_if req_ch ();
    pqm_rsp_if rsp_ch ();

    priority_queue_max_unit #(
        .QUEUE_DEPTH   (DEPTH),
        .PRIORITY_BITS (PRIO_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Requests still to be offered, and responses awaited in order of issue.
    queue_req_t req_backlog[$];
    queue_rsp_t awaited_rsp[$];

    // The bench's own picture of the entry store. Ages run 0..count-1 over
    // the held entries, 0 being the newest.
    logic signed [pqm_pkg::VALUE_W-1:0] slot_value [DEPTH];
    logic [pqm_pkg::PRIO_FIELD_W-1:0]   slot_prio  [DEPTH];
    int unsigned                        slot_age   [DEPTH];
    bit                                 slot_held  [DEPTH];
    int                                 held_count;

    int  sent_count;
    int  total_reqs;
    int  error_count;
    int  hold_left;
    bit  hold_done;
    int  cycle_count;
    int  fill_guess;

    // Neither side idles while the request count lies in this window.
    wire calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

    // ------------------------------------------------------------------
    // Clock, and the known values every input carries before reset ends.
    // ------------------------------------------------------------------
    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = pqm_pkg::CMD_ENQUEUE;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one accepted request to the model store and yields the
    // response the queue must give for it.
    task automatic serve_request(input queue_req_t r, output queue_rsp_t res);
        int best;
        int freed_age;
        int slot;
        logic [pqm_pkg::PRIO_FIELD_W-1:0] p;

        res.status = pqm_pkg::STATUS_OK;
        res.value  = '0;
        res.prio   = '0;
        p = r.prio & pqm_pkg::PRIO_FIELD_W'((64'd1 << PRIO_BITS) - 1);
        if (r.cmd == pqm_pkg::CMD_ENQUEUE)
        begin
            if (held_count >= DEPTH)
            begin
                res.status = pqm_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                slot = -1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!slot_held[i] && slot < 0)
                        slot = i;
                end
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_held[i])
                        slot_age[i]++;
                end
                slot_value[slot] = r.value;
                slot_prio[slot]  = p;
                slot_age[slot]   = 0;
                slot_held[slot]  = 1'b1;
                held_count++;
            end
        end
        else
        begin
            // Highest priority first; the newest entry breaks a tie.
            best = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (slot_held[i] &&
                    (best < 0 || slot_prio[i] > slot_prio[best] ||
                     (slot_prio[i] == slot_prio[best] && slot_age[i] < slot_age[best])))
                    best = i;
            end
            if (best < 0)
            begin
                res.status = pqm_pkg::STATUS_UNDERFLOW;
            end
            else
            begin
                res.value       = slot_value[best];
                res.prio        = slot_prio[best];
                freed_age       = slot_age[best];
                slot_held[best] = 1'b0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_held[i] && slot_age[i] > freed_age)
                        slot_age[i]--;
                end
                held_count--;
            end
        end
        res.fill = pqm_pkg::FILL_W'(held_count);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Queues one request and follows the fill level that it should leave.
    task automatic add_request(input logic cmd, input logic [31:0] value,
                               input logic [15:0] prio);
        queue_req_t r;

        r.cmd   = cmd;
        r.value = value;
        r.prio  = prio;
        req_backlog.push_back(r);
        if (cmd == pqm_pkg::CMD_ENQUEUE && fill_guess < DEPTH)
            fill_guess++;
        else if (cmd == pqm_pkg::CMD_DEQUEUE && fill_guess > 0)
            fill_guess--;
    endtask

    // ------------------------------------------------------------------
    // Request driver. A request stays on the channel until it is taken;
    // the moment it is taken, the model works out the matching response.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        queue_req_t taken;
        queue_req_t nxt;
        queue_rsp_t predicted;

        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.cmd           <= pqm_pkg::CMD_ENQUEUE;
            req_ch.item_value    <= '0;
            req_ch.item_priority <= '0;
            sent_count           <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.cmd   = req_ch.cmd;
                taken.value = req_ch.item_value;
                taken.prio  = req_ch.item_priority;
                serve_request(taken, predicted);
                awaited_rsp.push_back(predicted);
                sent_count <= sent_count + 1;
            end
            // A new request may go out only once the last one has been taken.
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = req_backlog.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.cmd           <= nxt.cmd;
                    req_ch.item_value    <= nxt.value;
                    req_ch.item_priority <= nxt.prio;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // One long receiver hold-off, so that a response sits unread while the
    // sender keeps offering and the queue has to stall its request side.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Response monitor. Each response taken is checked against the oldest
    // awaited one; ready is then decided afresh for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_responses
        queue_rsp_t want;

        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch("response with no request outstanding", 32'd0,
                                    32'(rsp_ch.status));
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
                    if (rsp_ch.out_value !== want.value)
                        report_mismatch("out_value", want.value, rsp_ch.out_value);
                    if (rsp_ch.out_priority !== want.prio)
                        report_mismatch("out_priority", 32'(want.prio),
                                        32'(rsp_ch.out_priority));
                    if (rsp_ch.fill_level !== want.fill)
                        report_mismatch("fill_level", 32'(want.fill),
                                        32'(rsp_ch.fill_level));
                end
            end
            rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // A hung queue must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase_left;
        int enq_pct;
        int prio_style;
        logic [15:0] p;

        cycle_count = 0;
        error_count = 0;
        fill_guess  = 0;
        held_count  = 0;
        for (int i = 0; i < DEPTH; i++)
            slot_held[i] = 1'b0;

        // Directed part: an underflow, the value and priority extremes, ties
        // between equal priorities, a full store and an overflow, then a few
        // removals that must come out highest first and newest first on a tie.
        add_request(pqm_pkg::CMD_DEQUEUE, 32'h1234_5678, 16'hFFFF);
        add_request(pqm_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF, 16'h0000);
        add_request(pqm_pkg::CMD_ENQUEUE, 32'h8000_0000, 16'hFFFF);
        add_request(pqm_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF, 16'h8000);
        add_request(pqm_pkg::CMD_ENQUEUE, 32'h0000_0000, 16'h8000);
        for (int i = 0; i < 12; i++)
            add_request(pqm_pkg::CMD_ENQUEUE, 32'hA5A5_0000 + i,
                        (i % 3 == 0) ? 16'hFFFF : 16'd5);
        add_request(pqm_pkg::CMD_ENQUEUE, 32'h5A5A_5A5A, 16'h7FFF);
        for (int i = 0; i < 6; i++)
            add_request(pqm_pkg::CMD_DEQUEUE, $urandom(), 16'($urandom()));

        // Random part: phases that lean towards filling, draining or neither, so the
        // store swings between empty and full, with random contents. Some
        // phases keep priorities to a handful of values to force many ties.
        phase_left = 0;
        enq_pct    = 50;
        prio_style = 0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 20;
                    default: enq_pct = 55;
                endcase
                prio_style = $urandom_range(2);
            end
            phase_left--;
            case (prio_style)
                0:       p = 16'($urandom_range(3));
                1:
                begin
                    if ($urandom_range(7) == 0)
                        p = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                    else
                        p = 16'($urandom());
                end
                default: p = 16'($urandom());
            endcase
            if ($urandom_range(99) < enq_pct)
                add_request(pqm_pkg::CMD_ENQUEUE, $urandom(), p);
            else
                add_request(pqm_pkg::CMD_DEQUEUE, $urandom(), p);
        end
        total_reqs = req_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_reqs)
            @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
